/* src/fpa_pkg.sv */
// Shared types and constants of the fixed pool free-list allocator.
// Depends on nothing; every other file of the block but fpa_ram imports it.
`default_nettype none
package fpa_pkg;

    localparam int POOL_DEPTH  = 256;
    localparam int OFFSET_BITS = 20;

    localparam int SIZE_W    = 13;
    localparam int COUNT_W   = 9;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 1;

    // slot number, and slot number plus one (list links, head, fresh mark)
    localparam int SLOT_W = $clog2(POOL_DEPTH);
    localparam int CNT_W  = $clog2(POOL_DEPTH + 1);

    localparam logic [SIZE_W-1:0]  SIZE_RESET  = SIZE_W'(16);
    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(256);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ELEMENT_SIZE  = 1'b0,
        REG_ELEMENT_COUNT = 1'b1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        FN_ALLOC    = 2'd0,
        FN_FREE     = 2'd1,
        FN_FREE_ALL = 2'd2,
        FN_CHECK    = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_INVALID = 2'd2
    } t_status;

    typedef struct packed {
        t_func                  func;
        logic [OFFSET_BITS-1:0] offset;
    } t_in_item;

    typedef struct packed {
        logic [OFFSET_BITS-1:0] slot_offset;
        t_status                status;
    } t_out_item;

    // divider result beat
    typedef struct packed {
        logic                   done;
        logic [OFFSET_BITS-1:0] quo;
        logic                   rem_zero;
    } t_div_res;

endpackage
`default_nettype wire

/* src/fpa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none
module fpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

/* src/fpa_div.sv */
// Bit-serial restoring divider: offset by slot size, one quotient bit a cycle.
// Depends on fpa_pkg.
`default_nettype none
module fpa_div (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [fpa_pkg::OFFSET_BITS-1:0] i_dividend,
    input  wire logic [fpa_pkg::SIZE_W-1:0]      i_divisor,
    output fpa_pkg::t_div_res                    o_res
);
    import fpa_pkg::*;

    localparam int CW = $clog2(OFFSET_BITS + 1);

    logic [CW-1:0]          r_cnt;
    logic                   r_busy;
    logic                   r_done;
    logic [OFFSET_BITS-1:0] r_quo;
    logic [SIZE_W-1:0]      r_rem;
    logic [SIZE_W-1:0]      r_dvs;
    logic [SIZE_W:0]        w_trial;
    logic                   w_fit;

    // shift the next dividend bit into the partial remainder
    assign w_trial = {r_rem, r_quo[OFFSET_BITS-1]};
    assign w_fit   = (w_trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_start) begin
                r_busy <= 1'b1;
                r_done <= 1'b0;
                r_cnt  <= CW'(OFFSET_BITS);
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                r_quo  <= {r_quo[OFFSET_BITS-2:0], w_fit};
                r_rem  <= w_fit ? SIZE_W'(w_trial - {1'b0, r_dvs}) : w_trial[SIZE_W-1:0];
                r_cnt  <= r_cnt - CW'(1);
                r_done <= (r_cnt == CW'(1));
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                end
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    assign o_res.done     = r_done;
    assign o_res.quo      = r_quo;
    assign o_res.rem_zero = (r_rem == '0);
endmodule
`default_nettype wire

/* src/fpa_mul.sv */
// Shift-add multiplier: slot number times slot size, one multiplier bit a cycle.
// Depends on fpa_pkg.
`default_nettype none
module fpa_mul (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    input  wire logic [fpa_pkg::SLOT_W-1:0]      i_slot,
    input  wire logic [fpa_pkg::SIZE_W-1:0]      i_size,
    output logic                                 o_done,
    output logic      [fpa_pkg::OFFSET_BITS-1:0] o_prod
);
    import fpa_pkg::*;

    localparam int CW = $clog2(SLOT_W + 1);

    logic [CW-1:0]          r_cnt;
    logic                   r_busy;
    logic [SLOT_W-1:0]      r_mpl;
    logic [OFFSET_BITS-1:0] r_mc;
    logic [OFFSET_BITS-1:0] r_acc;

    // product is kept modulo the offset width, as the slot offset wraps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_start) begin
                r_busy <= 1'b1;
                o_done <= 1'b0;
                r_cnt  <= CW'(SLOT_W);
                r_mpl  <= i_slot;
                r_mc   <= OFFSET_BITS'(i_size);
                r_acc  <= '0;
            end else if (r_busy) begin
                if (r_mpl[0]) begin
                    r_acc <= r_acc + r_mc;
                end
                r_mc   <= r_mc << 1;
                r_mpl  <= r_mpl >> 1;
                r_cnt  <= r_cnt - CW'(1);
                o_done <= (r_cnt == CW'(1));
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                end
            end else begin
                o_done <= 1'b0;
            end
        end
    end

    assign o_prod = r_acc;
endmodule
`default_nettype wire

/* src/fixed_pool_free_list_allocator.sv */
// Top level of the fixed pool free-list allocator: control, registers, link RAM.
// Depends on fpa_pkg, fpa_ram, fpa_div and fpa_mul.
//
// Hands out equal slots of a pool, named by byte offset (slot * element_size).
// Free slots form a LIFO list kept in a link RAM; slots not yet handed out
// since the last rebuild come from an ascending fresh range, so free all and
// any configuration write rebuild the list at once. One request is in work at
// a time. Alloc forms the offset with a bit-serial shift-add multiply; free
// and check divide the offset by the slot size with a bit-serial restoring
// divide; free all and an empty alloc go straight to the result. The next
// request is taken while a result still waits in the output register. Free
// of an offset outside the pool or off a slot boundary returns status
// invalid and changes nothing; double frees are not detected.
`default_nettype none
module fixed_pool_free_list_allocator (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [fpa_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [fpa_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire fpa_pkg::t_in_item             i_in_data,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output fpa_pkg::t_out_item                 o_out_data
);
    import fpa_pkg::*;

    localparam int EC_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam int QC_W = OFFSET_BITS + EC_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_DONE
    } t_state;

    t_state                 r_state;
    logic [SIZE_W-1:0]      r_size;
    logic [COUNT_W-1:0]     r_count;
    logic [CNT_W-1:0]       r_head;
    logic [CNT_W-1:0]       r_fresh;
    t_func                  r_func;
    logic                   r_from_list;
    logic [OFFSET_BITS-1:0] r_res_off;
    t_status                r_res_st;

    logic                   w_accept;
    logic [SIZE_W-1:0]      w_eff_size;
    logic [EC_W-1:0]        w_eff_cnt;
    logic                   w_pop;
    logic                   w_take_fresh;
    logic                   w_mul_start;
    logic                   w_div_start;
    logic                   w_mul_done;
    logic [OFFSET_BITS-1:0] w_prod;
    t_div_res               w_div;
    logic                   w_slot_ok;
    logic                   w_push;
    logic [CNT_W-1:0]       w_link;
    logic                   w_out_free;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign w_out_free = !o_out_valid || !i_out_stall;

    assign w_eff_size = (r_size == '0) ? SIZE_W'(1) : r_size;
    assign w_eff_cnt  = (EC_W'(r_count) > EC_W'(POOL_DEPTH)) ? EC_W'(POOL_DEPTH)
                                                            : EC_W'(r_count);

    assign w_pop        = w_accept && (i_in_data.func == FN_ALLOC) && (r_head != '0);
    assign w_take_fresh = w_accept && (i_in_data.func == FN_ALLOC) && (r_head == '0)
                          && (EC_W'(r_fresh) < w_eff_cnt);
    assign w_mul_start  = w_pop || w_take_fresh;
    assign w_div_start  = w_accept &&
                          ((i_in_data.func == FN_FREE) || (i_in_data.func == FN_CHECK));

    // quotient below the slot count is the same as offset below size * count
    assign w_slot_ok = w_div.rem_zero && (QC_W'(w_div.quo) < QC_W'(w_eff_cnt));
    assign w_push    = (r_state == S_DIV) && w_div.done && w_slot_ok && (r_func == FN_FREE);

    fpa_ram #(
        .WIDTH (CNT_W),
        .DEPTH (POOL_DEPTH)
    ) u_link (
        .i_clk   (i_clk),
        .i_we    (w_push),
        .i_waddr (w_div.quo[SLOT_W-1:0]),
        .i_wdata (r_head),
        .i_re    (w_pop),
        .i_raddr (SLOT_W'(r_head - CNT_W'(1))),
        .o_rdata (w_link)
    );

    fpa_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_slot  (w_pop ? SLOT_W'(r_head - CNT_W'(1)) : SLOT_W'(r_fresh)),
        .i_size  (w_eff_size),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    fpa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (i_in_data.offset),
        .i_divisor  (w_eff_size),
        .o_res      (w_div)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_size      <= SIZE_RESET;
            r_count     <= COUNT_RESET;
            r_head      <= '0;
            r_fresh     <= '0;
            r_from_list <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            // a waiting result reloads the output register in the same cycle
            if (o_out_valid && !i_out_stall && (r_state != S_DONE)) begin
                o_out_valid <= 1'b0;
            end

            // any listed register write rebuilds the list
            if (i_cfg_we) begin
                unique case (t_cfg_reg'(i_cfg_idx))
                    REG_ELEMENT_SIZE: begin
                        r_size <= i_cfg_data[SIZE_W-1:0];
                    end
                    REG_ELEMENT_COUNT: begin
                        r_count <= i_cfg_data[COUNT_W-1:0];
                    end
                endcase
                r_head  <= '0;
                r_fresh <= '0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_func      <= i_in_data.func;
                        r_res_off   <= '0;
                        r_res_st    <= ((i_in_data.func == FN_ALLOC) && !w_mul_start)
                                       ? ST_EMPTY : ST_OK;
                        r_from_list <= w_pop;
                        unique case (i_in_data.func)
                            FN_ALLOC: begin
                                if (w_mul_start) begin
                                    if (w_take_fresh) begin
                                        r_fresh <= r_fresh + CNT_W'(1);
                                    end
                                    r_state <= S_MUL;
                                end else begin
                                    r_state <= S_DONE;
                                end
                            end
                            FN_FREE, FN_CHECK: begin
                                r_state <= S_DIV;
                            end
                            FN_FREE_ALL: begin
                                r_head  <= '0;
                                r_fresh <= '0;
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_MUL: begin
                    if (w_mul_done) begin
                        r_res_off <= w_prod;
                        if (r_from_list) begin
                            r_head <= w_link;
                        end
                        r_state <= S_DONE;
                    end
                end
                S_DIV: begin
                    if (w_div.done) begin
                        if (!w_slot_ok) begin
                            r_res_st <= ST_INVALID;
                        end else if (r_func == FN_FREE) begin
                            r_head <= CNT_W'(w_div.quo[SLOT_W-1:0]) + CNT_W'(1);
                        end
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    // hold the result until the output register frees up
                    if (w_out_free) begin
                        o_out_data.slot_offset <= r_res_off;
                        o_out_data.status      <= r_res_st;
                        o_out_valid            <= 1'b1;
                        r_state                <= S_IDLE;
                    end
                end
            endcase
        end
    end
endmodule
`default_nettype wire

/* src/fpa_checker.sv */
// Port-level checker for the fixed pool free-list allocator, bound to the top.
// Depends on fpa_pkg and fixed_pool_free_list_allocator.
`default_nettype none
module fpa_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_stall,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire fpa_pkg::t_out_item o_out_data
);
    import fpa_pkg::*;

    // a stalled result beat stays
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_data))
        else $error("result beat changed while stalled");

    // a failed request carries a zero offset
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status != ST_OK) |-> (o_out_data.slot_offset == '0))
        else $error("failed request returned an offset");

    // one request at a time: the block is busy right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second request taken while one is in work");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.status != 2'd3))
        else $error("status code out of range");
endmodule

bind fixed_pool_free_list_allocator fpa_checker u_fpa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
`default_nettype wire

/* test/fixed_pool_free_list_allocator_tb.sv */
// Self-checking testbench for fixed_pool_free_list_allocator: directed and random
// alloc / free / free all / check traffic against a built-in free-list predictor.
// Depends on fpa_pkg and the allocator RTL only.
`timescale 1ns / 1ps
module fixed_pool_free_list_allocator_tb;
    import fpa_pkg::*;

    localparam int HALF_NS       = 6;
    localparam int CYCLE_LIMIT   = 800000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 40;
    localparam int MAX_REPORTS   = 10;
    localparam int TARGET_ITEMS  = 1900;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx  = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 req_valid = 1'b0;
    t_in_item             req_beat  = '0;
    logic                 req_stall;
    logic                 rsp_valid;
    logic                 rsp_stall = 1'b0;
    t_out_item            rsp_beat;

    // predictor state
    logic [SIZE_W-1:0]  cur_size   = SIZE_RESET;
    logic [COUNT_W-1:0] cur_count  = COUNT_RESET;
    logic [CNT_W-1:0]   list_head  = '0;
    logic [CNT_W-1:0]   next_fresh = '0;
    logic [CNT_W-1:0]   link_of [POOL_DEPTH];

    t_out_item              pending_results[$];
    logic [OFFSET_BITS-1:0] owned_slots[$];

    int  cycle_count    = 0;
    int  mismatch_count = 0;
    int  sent_items     = 0;
    int  writes_done    = 0;
    int  empty_seen     = 0;
    int  invalid_seen   = 0;
    int  func_hits[4]   = '{0, 0, 0, 0};
    bit  hold_rsp       = 1'b0;
    bit  no_idle        = 1'b0;

    always begin
        #HALF_NS clk = 1'b1;
        #HALF_NS clk = 1'b0;
    end

    fixed_pool_free_list_allocator uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (req_valid),
        .o_in_stall  (req_stall),
        .i_in_data   (req_beat),
        .o_out_valid (rsp_valid),
        .i_out_stall (rsp_stall),
        .o_out_data  (rsp_beat)
    );

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout at cycle %0d with %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    always @(posedge clk) begin : check_results
        t_out_item want;
        if (rst_n && rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("cycle %0d: unexpected beat, offset %h status %0d",
                             cycle_count, rsp_beat.slot_offset, rsp_beat.status);
            end else begin
                want = pending_results.pop_front();
                if (rsp_beat.slot_offset !== want.slot_offset ||
                    rsp_beat.status !== want.status) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display({"cycle %0d: expected offset %h status %0d,",
                                  " got offset %h status %0d"},
                                 cycle_count, want.slot_offset, want.status,
                                 rsp_beat.slot_offset, rsp_beat.status);
                end
            end
        end
    end

    // mostly no gap, some short ones, a few long ones
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // receiver: random stall segments, or one long hold when asked
    initial begin : drive_rsp_stall
        int n;
        forever begin
            if (hold_rsp) begin
                rsp_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_rsp = 1'b0;
            end else begin
                n = idle_len();
                rsp_stall <= (n != 0);
                repeat (n != 0 ? n : $urandom_range(1, 6)) @(posedge clk);
            end
        end
    end

    function automatic longint slot_bytes();
        return (cur_size == 0) ? 64'd1 : longint'(cur_size);
    endfunction

    function automatic int live_slots();
        return (cur_count > POOL_DEPTH) ? POOL_DEPTH : int'(cur_count);
    endfunction

    // advance the free list by one request and return the result it gives
    function automatic t_out_item serve_request(input t_in_item rq);
        t_out_item res;
        longint    sz;
        longint    lim;
        longint    prod;
        int        slot;
        bit        on_slot;
        sz      = slot_bytes();
        lim     = sz * live_slots();
        on_slot = (longint'(rq.offset) < lim) && (longint'(rq.offset) % sz == 0);
        res.slot_offset = '0;
        res.status      = ST_OK;
        case (rq.func)
            FN_ALLOC: begin
                slot = -1;
                if (list_head != 0) begin
                    slot      = int'(list_head) - 1;
                    list_head = link_of[slot];
                end else if (next_fresh < live_slots()) begin
                    slot       = int'(next_fresh);
                    next_fresh = next_fresh + 1'b1;
                end else begin
                    res.status = ST_EMPTY;
                end
                if (slot >= 0) begin
                    prod            = slot * sz;
                    res.slot_offset = prod[OFFSET_BITS-1:0];
                end
            end
            FN_FREE: begin
                if (on_slot) begin
                    slot          = int'(longint'(rq.offset) / sz);
                    link_of[slot] = list_head;
                    list_head     = CNT_W'(slot + 1);
                end else begin
                    res.status = ST_INVALID;
                end
            end
            FN_FREE_ALL: begin
                list_head  = '0;
                next_fresh = '0;
            end
            default: begin
                if (!on_slot)
                    res.status = ST_INVALID;
            end
        endcase
        return res;
    endfunction

    // offer one beat, hold it until taken, then log what it should produce
    task automatic send_request(input t_func fn, input logic [OFFSET_BITS-1:0] off);
        int        gap;
        t_in_item  beat;
        t_out_item res;
        gap         = idle_len();
        beat.func   = fn;
        beat.offset = off;
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_beat  <= beat;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        res = serve_request(beat);
        pending_results.push_back(res);
        sent_items++;
        func_hits[fn]++;
        if (res.status == ST_EMPTY)
            empty_seen++;
        if (res.status == ST_INVALID)
            invalid_seen++;
        if (fn == FN_ALLOC && res.status == ST_OK)
            owned_slots.push_back(res.slot_offset);
        if (fn == FN_FREE_ALL)
            owned_slots.delete();
    endtask

    task automatic wait_idle();
        req_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input t_cfg_reg which, input logic [CFG_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= which;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (which == REG_ELEMENT_SIZE)
            cur_size = value;
        else
            cur_count = value[COUNT_W-1:0];
        list_head  = '0;
        next_fresh = '0;
        owned_slots.delete();
        writes_done++;
    endtask

    task automatic configure(input logic [CFG_W-1:0] size, input logic [CFG_W-1:0] count);
        wait_idle();
        if ($urandom_range(0, 1)) begin
            write_reg(REG_ELEMENT_SIZE, size);
            write_reg(REG_ELEMENT_COUNT, count);
        end else begin
            write_reg(REG_ELEMENT_COUNT, count);
            write_reg(REG_ELEMENT_SIZE, size);
        end
    endtask

    // offsets around the pool: past the end, last slot, off boundary, any slot, noise
    function automatic logic [OFFSET_BITS-1:0] stray_offset();
        longint sz;
        longint lim;
        longint pick;
        sz  = slot_bytes();
        lim = sz * live_slots();
        case ($urandom_range(0, 5))
            0: pick = lim;
            1: pick = lim - sz;
            2: pick = $urandom_range(0, POOL_DEPTH) * sz + $urandom_range(1, int'(sz) - 1);
            3: pick = $urandom_range(0, POOL_DEPTH) * sz;
            4: pick = {OFFSET_BITS{1'b1}};
            default: pick = longint'($urandom);
        endcase
        return pick[OFFSET_BITS-1:0];
    endfunction

    task automatic send_random_request();
        int                     pick;
        int                     idx;
        logic [OFFSET_BITS-1:0] off;
        off  = OFFSET_BITS'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 38) begin
            send_request(FN_ALLOC, off);
        end else if (pick < 70 || pick >= 72) begin
            if (owned_slots.size() != 0 && $urandom_range(0, 9) < 8) begin
                idx = $urandom_range(0, owned_slots.size() - 1);
                off = owned_slots[idx];
                // now and then keep it owned so it gets freed twice
                if (pick < 70 && $urandom_range(0, 19) != 0)
                    owned_slots.delete(idx);
            end else if ($urandom_range(0, 3) != 0) begin
                off = stray_offset();
            end
            send_request(pick < 70 ? FN_FREE : FN_CHECK, off);
        end else begin
            send_request(FN_FREE_ALL, off);
        end
    endtask

    task automatic test_reset_values();
        send_request(FN_ALLOC, '0);
        send_request(FN_ALLOC, '1);
        send_request(FN_ALLOC, '0);
        send_request(FN_FREE, 20'd16);
        send_request(FN_ALLOC, '0);
        send_request(FN_FREE, 20'd0);
        send_request(FN_FREE, 20'd32);
        send_request(FN_ALLOC, '0);
        send_request(FN_ALLOC, '0);
        send_request(FN_CHECK, 20'd0);
        send_request(FN_CHECK, 20'd4080);
        send_request(FN_CHECK, 20'd4096);
        send_request(FN_CHECK, 20'd8);
        send_request(FN_CHECK, '1);
        send_request(FN_FREE, 20'd4096);
        send_request(FN_FREE, '1);
        send_request(FN_FREE, 20'd7);
        send_request(FN_FREE_ALL, '1);
        send_request(FN_ALLOC, '0);
        send_request(FN_ALLOC, '0);
    endtask

    task automatic test_register_extremes();
        // size zero acts as one byte
        configure(13'd0, 13'd2);
        send_request(FN_ALLOC, '0);
        send_request(FN_ALLOC, '0);
        send_request(FN_ALLOC, '0);
        send_request(FN_CHECK, 20'd1);
        send_request(FN_CHECK, 20'd2);
        send_request(FN_FREE, 20'd1);
        send_request(FN_ALLOC, '0);
        // empty pool
        configure(13'd16, 13'd0);
        send_request(FN_ALLOC, '0);
        send_request(FN_CHECK, 20'd0);
        send_request(FN_FREE, 20'd0);
        // count above the pool depth saturates
        configure(13'd9, 13'd300);
        send_request(FN_CHECK, 20'd2295);
        send_request(FN_CHECK, 20'd2304);
        configure(13'd4096, 13'd1);
        send_request(FN_ALLOC, '0);
        send_request(FN_ALLOC, '0);
        send_request(FN_FREE_ALL, '0);
        send_request(FN_ALLOC, '0);
        configure(13'h1FFF, 13'h1FFF);
        send_request(FN_CHECK, '1);
        send_request(FN_ALLOC, '0);
    endtask

    // fill a pool whose far slots wrap past the offset width
    task automatic test_pool_wrap();
        int idx;
        configure(13'h1FFF, 13'd256);
        repeat (POOL_DEPTH + 1) send_request(FN_ALLOC, OFFSET_BITS'($urandom));
        repeat (8) begin
            idx = $urandom_range(0, owned_slots.size() - 1);
            send_request(FN_CHECK, owned_slots[idx]);
            send_request(FN_FREE, owned_slots[idx]);
        end
        repeat (4) send_request(FN_ALLOC, '0);
        send_request(FN_FREE_ALL, '0);
    endtask

    task automatic test_backpressure();
        configure(13'($urandom_range(9, 200)), 13'($urandom_range(4, 32)));
        hold_rsp = 1'b1;
        repeat (40) send_random_request();
        wait_idle();
    endtask

    task automatic test_random_traffic();
        int phase;
        int len;
        logic [CFG_W-1:0] size;
        logic [CFG_W-1:0] count;
        phase = 0;
        while (sent_items < TARGET_ITEMS) begin
            case ($urandom_range(0, 5))
                0: size = CFG_W'($urandom_range(0, 8));
                1: size = 13'd4096;
                2: size = CFG_W'($urandom);
                default: size = CFG_W'($urandom_range(9, 128));
            endcase
            case ($urandom_range(0, 9))
                0: count = 13'd0;
                1: count = 13'd256;
                2: count = CFG_W'($urandom_range(257, 511));
                3, 4: count = CFG_W'($urandom_range(9, 64));
                default: count = CFG_W'($urandom_range(1, 8));
            endcase
            // junk above the count field must be dropped
            count[CFG_W-1:COUNT_W] = (CFG_W - COUNT_W)'($urandom);
            if ($urandom_range(0, 3) == 0) begin
                wait_idle();
                if ($urandom_range(0, 1))
                    write_reg(REG_ELEMENT_SIZE, size);
                else
                    write_reg(REG_ELEMENT_COUNT, count);
            end else begin
                configure(size, count);
            end
            no_idle = (phase % 5 == 2);
            len = $urandom_range(60, 200);
            repeat (len) send_random_request();
            no_idle = 1'b0;
            phase++;
        end
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_values();
        test_register_extremes();
        test_pool_wrap();
        test_backpressure();
        test_random_traffic();
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display({"ran %0d requests (%0d alloc, %0d free, %0d free all, %0d check),",
                  " %0d register writes"},
                 sent_items, func_hits[FN_ALLOC], func_hits[FN_FREE],
                 func_hits[FN_FREE_ALL], func_hits[FN_CHECK], writes_done);
        $display("pool empty seen %0d times, invalid offset %0d times, %0d mismatches",
                 empty_seen, invalid_seen, mismatch_count);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
